>>> sv/rpsa_pkg.sv
package rpsa_pkg;

  localparam int unsigned SLOTS_DEF   = 128;
  localparam int unsigned SOURCES_DEF = 256;

  localparam logic [2:0] CMD_ALLOC_IDX   = 3'd0;
  localparam logic [2:0] CMD_RELEASE_IDX = 3'd1;
  localparam logic [2:0] CMD_FIND_IDX    = 3'd2;
  localparam logic [2:0] CMD_ALLOC_RAW   = 3'd3;
  localparam logic [2:0] CMD_FIND_RAW    = 3'd4;
  localparam logic [2:0] CMD_RELEASE_RAW = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_SLOT   = 2'd2;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  typedef struct packed {
    logic capture;
    logic dispatch;
    logic free_step;
    logic raw_step;
    logic deliver;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_free;
    logic go_raw;
    logic free_done;
    logic raw_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [14:0] code_of(input logic [7:0] slot);
    return {slot[6:0], 8'd0};
  endfunction

endpackage

>>> sv/rpsa_ctrl.sv
module rpsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rpsa_pkg::dp_stat_t   stat_i,
  output rpsa_pkg::ctrl_cmd_t  ctl_o
);
  import rpsa_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_FREE = 3'd2;
  localparam logic [2:0] S_RAW  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        ctl_o.dispatch = 1'b1;
        priority if (stat_i.go_free) state_d = S_FREE;
        else if (stat_i.go_raw)     state_d = S_RAW;
        else                        state_d = S_DONE;
      end
      S_FREE: begin
        ctl_o.free_step = 1'b1;
        if (stat_i.free_done) state_d = S_DONE;
      end
      S_RAW: begin
        ctl_o.raw_step = 1'b1;
        if (stat_i.raw_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          ctl_o.deliver = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/rpsa_datapath.sv
module rpsa_datapath #(
  parameter int unsigned SLOTS   = rpsa_pkg::SLOTS_DEF,
  parameter int unsigned SOURCES = rpsa_pkg::SOURCES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           src_index_i,
  input  logic [31:0]          raw_key_i,
  input  logic [14:0]          code_in_i,
  input  rpsa_pkg::ctrl_cmd_t  ctl_i,
  output rpsa_pkg::dp_stat_t   stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [14:0]          pal_code_o,
  output logic                 load_request_o,
  output logic                 load_is_raw_o
);
  import rpsa_pkg::*;

  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned MAP_DEPTH = (SOURCES < 256) ? SOURCES : 256;
  localparam int unsigned MAP_W     = $clog2(MAP_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // transaction fields
  logic [2:0]  cmd_q;
  logic [7:0]  src_q;
  logic [31:0] key_q;
  logic [6:0]  rslot_q;

  // source map entry read at capture
  logic [7:0]  ent_slot_q;
  logic [15:0] ent_cnt_q;
  logic        ent_vld_q;

  logic [SLOTS-1:0]     busy_q, raw_q;
  logic [MAP_DEPTH-1:0] map_vld_q;
  logic [23:0]          map_mem [MAP_DEPTH];
  logic [31:0]          raw_mem [SLOTS];

  logic [SLOT_W-1:0] ptr_q, cslot_q;
  logic              pv_q, chk_q;
  logic [31:0]       tag_q;

  logic [1:0]  res_status_q, res_status_d;
  logic [14:0] res_code_q, res_code_d;
  logic        res_load_q, res_load_d, res_lraw_q, res_lraw_d;
  logic        res_we;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [14:0] out_code_q;
  logic        out_load_q, out_lraw_q;

  logic              src_ok, rs_ok, rs_owned, is_idx, ent_hit;
  logic [MAP_W-1:0]  map_idx;
  logic [SLOT_W-1:0] rs_idx, ent_idx;
  logic [15:0]       cnt_inc;
  logic              free_here, free_last, take, hit, raw_last;
  logic              rel_idx, rel_zero, rel_raw, inc_idx;
  logic              map_we;
  logic [23:0]       map_wdata;

  assign src_ok   = 32'(src_q) < 32'(SOURCES);
  assign map_idx  = MAP_W'(src_q);
  assign rs_ok    = 32'(rslot_q) < 32'(SLOTS);
  assign rs_idx   = SLOT_W'(rslot_q);
  assign rs_owned = rs_ok && busy_q[rs_idx] && raw_q[rs_idx];
  assign ent_idx  = SLOT_W'(ent_slot_q);
  assign is_idx   = (cmd_q == CMD_ALLOC_IDX) || (cmd_q == CMD_RELEASE_IDX) ||
                    (cmd_q == CMD_FIND_IDX);
  assign ent_hit  = is_idx && src_ok && ent_vld_q;
  assign cnt_inc  = (ent_cnt_q == COUNT_MAX) ? ent_cnt_q : ent_cnt_q + 16'd1;

  assign inc_idx  = ctl_i.dispatch && ent_hit && (cmd_q == CMD_ALLOC_IDX);
  assign rel_idx  = ctl_i.dispatch && ent_hit && (cmd_q == CMD_RELEASE_IDX);
  assign rel_zero = rel_idx && (ent_cnt_q <= 16'd1);
  assign rel_raw  = ctl_i.dispatch && (cmd_q == CMD_RELEASE_RAW) && rs_owned;

  assign free_here = !busy_q[ptr_q];
  assign free_last = (ptr_q == LAST_SLOT);
  assign take      = ctl_i.free_step && free_here;
  assign hit       = pv_q && chk_q && (tag_q == key_q);
  assign raw_last  = pv_q && (cslot_q == LAST_SLOT);

  assign stat_o.go_free   = ((cmd_q == CMD_ALLOC_IDX) && src_ok && !ent_vld_q) ||
                            (cmd_q == CMD_ALLOC_RAW);
  assign stat_o.go_raw    = (cmd_q == CMD_FIND_RAW);
  assign stat_o.free_done = free_here || free_last;
  assign stat_o.raw_done  = hit || raw_last;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    map_we    = 1'b0;
    map_wdata = {ent_slot_q, cnt_inc};
    if (inc_idx) begin
      map_we = 1'b1;
    end else if (rel_idx && !rel_zero) begin
      map_we    = 1'b1;
      map_wdata = {ent_slot_q, ent_cnt_q - 16'd1};
    end else if (take && (cmd_q == CMD_ALLOC_IDX)) begin
      map_we    = 1'b1;
      map_wdata = {8'(ptr_q), 16'd1};
    end
  end

  always_comb begin
    res_we       = 1'b0;
    res_status_d = ST_NOT_FOUND;
    res_code_d   = '0;
    res_load_d   = 1'b0;
    res_lraw_d   = 1'b0;
    priority if (ctl_i.dispatch) begin
      res_we = 1'b1;
      if (ent_hit) begin
        res_status_d = ST_OK;
        res_code_d   = code_of(ent_slot_q);
      end else if (rel_raw) begin
        res_status_d = ST_OK;
        res_code_d   = code_of(8'(rslot_q));
      end
    end else if (ctl_i.free_step) begin
      res_we = free_here || free_last;
      if (free_here) begin
        res_status_d = ST_OK;
        res_code_d   = code_of(8'(ptr_q));
        res_load_d   = 1'b1;
        res_lraw_d   = (cmd_q == CMD_ALLOC_RAW);
      end else begin
        res_status_d = ST_NO_SLOT;
      end
    end else if (ctl_i.raw_step) begin
      res_we = hit || raw_last;
      if (hit) begin
        res_status_d = ST_OK;
        res_code_d   = code_of(8'(cslot_q));
      end
    end else begin
      res_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q   <= cmd_i;
      src_q   <= src_index_i;
      key_q   <= raw_key_i;
      rslot_q <= code_in_i[14:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      {ent_slot_q, ent_cnt_q} <= map_mem[MAP_W'(src_index_i)];
      ent_vld_q               <= map_vld_q[MAP_W'(src_index_i)];
    end
    if (map_we) begin
      map_mem[map_idx] <= map_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.raw_step) begin
      tag_q <= raw_mem[ptr_q];
    end
    if (take && (cmd_q == CMD_ALLOC_RAW)) begin
      raw_mem[ptr_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      raw_q     <= '0;
      map_vld_q <= '0;
    end else begin
      if (rel_zero) begin
        busy_q[ent_idx]    <= 1'b0;
        raw_q[ent_idx]     <= 1'b0;
        map_vld_q[map_idx] <= 1'b0;
      end
      if (rel_raw) begin
        busy_q[rs_idx] <= 1'b0;
        raw_q[rs_idx]  <= 1'b0;
      end
      if (take) begin
        busy_q[ptr_q] <= 1'b1;
        raw_q[ptr_q]  <= (cmd_q == CMD_ALLOC_RAW);
        if (cmd_q == CMD_ALLOC_IDX) begin
          map_vld_q[map_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      pv_q    <= 1'b0;
      chk_q   <= 1'b0;
      cslot_q <= '0;
    end else begin
      if (ctl_i.dispatch) begin
        ptr_q <= '0;
        pv_q  <= 1'b0;
      end else if (ctl_i.free_step) begin
        if (!free_here && !free_last) ptr_q <= ptr_q + 1'b1;
      end else if (ctl_i.raw_step) begin
        pv_q    <= 1'b1;
        chk_q   <= busy_q[ptr_q] && raw_q[ptr_q];
        cslot_q <= ptr_q;
        if (ptr_q != LAST_SLOT) ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_status_q <= res_status_d;
      res_code_q   <= res_code_d;
      res_load_q   <= res_load_d;
      res_lraw_q   <= res_lraw_d;
    end
    if (ctl_i.deliver) begin
      out_status_q <= res_status_q;
      out_code_q   <= res_code_q;
      out_load_q   <= res_load_q;
      out_lraw_q   <= res_lraw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.deliver) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign pal_code_o     = out_code_q;
  assign load_request_o = out_load_q;
  assign load_is_raw_o  = out_lraw_q;

endmodule

>>> sv/refcounted_palette_slot_allocator.sv
// Palette slot allocator: one transaction in, one result out. A command that needs no
// search goes from acceptance through the dispatch and done states into the output
// register; the next transaction is accepted only once the controller is back in idle.
// Allocations that take a fresh slot walk the busy bits one slot per cycle, and a raw find
// walks the tag RAM one entry per cycle through its registered read port.
// One command is in flight at a time; a finished result sits in the output register while
// the next is accepted. A result that finds that register still held waits for it, and
// the input stays stalled until the held result is taken.
module refcounted_palette_slot_allocator #(
  parameter int unsigned SLOTS   = rpsa_pkg::SLOTS_DEF,
  parameter int unsigned SOURCES = rpsa_pkg::SOURCES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  src_index_i,
  input  logic [31:0] raw_key_i,
  input  logic [14:0] code_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [14:0] pal_code_o,
  output logic        load_request_o,
  output logic        load_is_raw_o
);
  import rpsa_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  rpsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  rpsa_datapath #(
    .SLOTS   (SLOTS),
    .SOURCES (SOURCES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .src_index_i    (src_index_i),
    .raw_key_i      (raw_key_i),
    .code_in_i      (code_in_i),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .pal_code_o     (pal_code_o),
    .load_request_o (load_request_o),
    .load_is_raw_o  (load_is_raw_o)
  );

endmodule

>>> sv/rpsa_checker.sv
module rpsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [2:0]  cmd_i,
  input logic [7:0]  src_index_i,
  input logic [31:0] raw_key_i,
  input logic [14:0] code_in_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [14:0] pal_code_o,
  input logic        load_request_o,
  input logic        load_is_raw_o
);
  import rpsa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(pal_code_o) && $stable(load_request_o) && $stable(load_is_raw_o))
    else $error("result changed while stalled");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (pal_code_o == 15'd0) && !load_request_o)
    else $error("failed transaction carries code or load");

  a_raw_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && load_is_raw_o |-> load_request_o)
    else $error("raw load flag without load request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_NOT_FOUND) ||
      (status_o == ST_NO_SLOT))
    else $error("illegal status");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a second transaction while busy");

endmodule

bind refcounted_palette_slot_allocator rpsa_checker u_rpsa_checker (.*);

>>> verif/palette_alloc_checker.sv
module palette_alloc_checker #(
  parameter int unsigned SLOTS   = rpsa_pkg::SLOTS_DEF,
  parameter int unsigned SOURCES = rpsa_pkg::SOURCES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  src_index_i,
  input  logic [31:0] raw_key_i,
  input  logic [14:0] code_in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [14:0] pal_code_i,
  input  logic        load_request_i,
  input  logic        load_is_raw_i,
  output int          err_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import rpsa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] code;
    logic        load;
    logic        load_raw;
  } palette_result_t;

  logic        slot_busy [SLOTS];
  logic        slot_raw  [SLOTS];
  logic [31:0] raw_tag   [SLOTS];
  logic [23:0] src_map   [SOURCES];

  palette_result_t expected_palette_q [$];
  int errors = 0;

  function automatic logic [14:0] slot_to_code(input int unsigned s);
    return 15'((s << 8) & 32'h7fff);
  endfunction

  function automatic int first_free_slot();
    for (int s = 0; s < SLOTS; s++) begin
      if (!slot_busy[s]) return s;
    end
    return -1;
  endfunction

  function automatic palette_result_t predict_palette(input logic [2:0]  c,
                                                     input logic [7:0]  src,
                                                     input logic [31:0] key,
                                                     input logic [14:0] ci);
    palette_result_t res;
    logic [23:0]     entry;
    int unsigned     slot;
    int unsigned     cnt;
    int unsigned     rslot;
    int              fs;
    logic            src_ok;
    res.status   = ST_NOT_FOUND;
    res.code     = '0;
    res.load     = 1'b0;
    res.load_raw = 1'b0;
    src_ok = (int'(src) < SOURCES);
    entry  = src_ok ? src_map[src] : '0;
    slot   = 32'(entry[23:16]);
    cnt    = 32'(entry[15:0]);
    rslot  = 32'(ci[14:8]);
    if (c <= CMD_FIND_IDX) begin
      if (src_ok) begin
        case (c)
          CMD_ALLOC_IDX: begin
            if (entry != '0) begin
              if (cnt < 32'(COUNT_MAX)) cnt++;
              src_map[src] = {8'(slot), 16'(cnt)};
              res.status = ST_OK;
              res.code   = slot_to_code(slot);
            end else begin
              fs = first_free_slot();
              if (fs < 0) begin
                res.status = ST_NO_SLOT;
              end else begin
                slot_busy[fs] = 1'b1;
                slot_raw[fs]  = 1'b0;
                src_map[src]  = {8'(fs), 16'd1};
                res.status = ST_OK;
                res.code   = slot_to_code(fs);
                res.load   = 1'b1;
              end
            end
          end
          CMD_RELEASE_IDX: begin
            if (entry != '0) begin
              res.status = ST_OK;
              res.code   = slot_to_code(slot);
              if (cnt > 0) cnt--;
              if (cnt == 0) begin
                src_map[src] = '0;
                if (slot < SLOTS) begin
                  slot_busy[slot] = 1'b0;
                  slot_raw[slot]  = 1'b0;
                end
              end else begin
                src_map[src] = {8'(slot), 16'(cnt)};
              end
            end
          end
          default: begin
            if (entry != '0) begin
              res.status = ST_OK;
              res.code   = slot_to_code(slot);
            end
          end
        endcase
      end
    end else begin
      case (c)
        CMD_ALLOC_RAW: begin
          fs = first_free_slot();
          if (fs < 0) begin
            res.status = ST_NO_SLOT;
          end else begin
            slot_busy[fs] = 1'b1;
            slot_raw[fs]  = 1'b1;
            raw_tag[fs]   = key;
            res.status   = ST_OK;
            res.code     = slot_to_code(fs);
            res.load     = 1'b1;
            res.load_raw = 1'b1;
          end
        end
        CMD_FIND_RAW: begin
          for (int s = 0; s < SLOTS; s++) begin
            if (res.status != ST_OK && slot_busy[s] && slot_raw[s] && raw_tag[s] == key) begin
              res.status = ST_OK;
              res.code   = slot_to_code(s);
            end
          end
        end
        CMD_RELEASE_RAW: begin
          if (rslot < SLOTS && slot_busy[rslot] && slot_raw[rslot]) begin
            slot_busy[rslot] = 1'b0;
            slot_raw[rslot]  = 1'b0;
            raw_tag[rslot]   = '0;
            res.status = ST_OK;
            res.code   = slot_to_code(rslot);
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    palette_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_busy[s] = 1'b0;
        slot_raw[s]  = 1'b0;
        raw_tag[s]   = '0;
      end
      for (int i = 0; i < SOURCES; i++) src_map[i] = '0;
      expected_palette_q.delete();
      pending_o   <= 0;
      err_count_o <= errors;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_palette_q.push_back(predict_palette(cmd_i, src_index_i, raw_key_i, code_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_palette_q.size() == 0) begin
          $error("palette result with no transaction waiting");
          errors++;
        end else begin
          want = expected_palette_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errors++;
          end
          if (pal_code_i !== want.code) begin
            $error("pal_code: expected 0x%0h, got 0x%0h", want.code, pal_code_i);
            errors++;
          end
          if (load_request_i !== want.load) begin
            $error("load_request: expected %0d, got %0d", want.load, load_request_i);
            errors++;
          end
          if (load_is_raw_i !== want.load_raw) begin
            $error("load_is_raw: expected %0d, got %0d", want.load_raw, load_is_raw_i);
            errors++;
          end
        end
      end
      pending_o   <= expected_palette_q.size();
      err_count_o <= errors;
    end
  end

endmodule

>>> verif/tb.sv
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import rpsa_pkg::*;

  localparam logic [2:0] CMD_RESERVED_A = 3'd6;
  localparam logic [2:0] CMD_RESERVED_B = 3'd7;
  localparam int         CYCLE_LIMIT    = 10_000_000;
  localparam int         HOLD_AFTER     = 120;
  localparam int         HOLD_CYCLES    = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  cmd;
  logic [7:0]  src_index;
  logic [31:0] raw_key;
  logic [14:0] code_in;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [14:0] pal_code;
  logic        load_request;
  logic        load_is_raw;

  int failures;
  int pending;
  int cycle_count = 0;
  bit calm = 1'b0;

  logic [31:0] key_pool [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
                                32'h1234_5678, 32'hdead_beef, 32'ha5a5_a5a5, 32'h5a5a_5a5a};

  always #4 clk_i = ~clk_i;

  refcounted_palette_slot_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .src_index_i    (src_index),
    .raw_key_i      (raw_key),
    .code_in_i      (code_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status),
    .pal_code_o     (pal_code),
    .load_request_o (load_request),
    .load_is_raw_o  (load_is_raw)
  );

  palette_alloc_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .src_index_i    (src_index),
    .raw_key_i      (raw_key),
    .code_in_i      (code_in),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .status_i       (status),
    .pal_code_i     (pal_code),
    .load_request_i (load_request),
    .load_is_raw_i  (load_is_raw),
    .err_count_o    (failures),
    .pending_o      (pending)
  );

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_cmd(input logic [2:0] c, input logic [7:0] s, input logic [31:0] k,
                          input logic [14:0] ci);
    int gap;
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    src_index <= s;
    raw_key   <= k;
    code_in   <= ci;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // fill phases lean on allocation to reach a full table, drain phases on release
  task automatic random_cmd(input bit fill);
    int          r;
    logic [2:0]  c;
    logic [7:0]  s;
    logic [31:0] k;
    logic [14:0] ci;
    r  = $urandom_range(0, 99);
    s  = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
    k  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : 32'($urandom());
    ci = {7'($urandom_range(0, 127)), 8'($urandom())};
    if (fill) begin
      if (r < 40)      c = CMD_ALLOC_RAW;
      else if (r < 80) c = CMD_ALLOC_IDX;
      else if (r < 86) c = CMD_FIND_IDX;
      else if (r < 92) c = CMD_FIND_RAW;
      else if (r < 95) c = CMD_RELEASE_IDX;
      else if (r < 98) c = CMD_RELEASE_RAW;
      else             c = $urandom_range(0, 1) ? CMD_RESERVED_A : CMD_RESERVED_B;
    end else begin
      if (r < 10)      c = CMD_ALLOC_IDX;
      else if (r < 20) c = CMD_ALLOC_RAW;
      else if (r < 50) c = CMD_RELEASE_IDX;
      else if (r < 80) c = CMD_RELEASE_RAW;
      else if (r < 88) c = CMD_FIND_IDX;
      else if (r < 96) c = CMD_FIND_RAW;
      else             c = $urandom_range(0, 1) ? CMD_RESERVED_A : CMD_RESERVED_B;
    end
    send_cmd(c, s, k, ci);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // receiver: random back-pressure plus one long hold so the input side stalls
  initial begin
    int  stall_left;
    int  n_out;
    bit  held;
    stall_left = 0;
    n_out      = 0;
    held       = 1'b0;
    out_ready <= 1'b0;
    repeat (11) @(posedge clk_i);
    forever begin
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_cycles();
      end
      @(posedge clk_i);
      if (out_valid && out_ready) n_out++;
      if (!held && n_out >= HOLD_AFTER) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end
    end
  end

  initial begin
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    cmd       <= CMD_FIND_IDX;
    src_index <= '0;
    raw_key   <= '0;
    code_in   <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, reuse, partial release, raw tags, illegal releases
    send_cmd(CMD_FIND_IDX,    8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RELEASE_IDX, 8'd255, 32'h0,         15'h0000);
    send_cmd(CMD_FIND_RAW,    8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RELEASE_RAW, 8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_ALLOC_IDX,   8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_ALLOC_IDX,   8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RELEASE_IDX, 8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_FIND_IDX,    8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_ALLOC_IDX,   8'd255, 32'hffff_ffff, 15'h7fff);
    send_cmd(CMD_ALLOC_RAW,   8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_FIND_RAW,    8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_ALLOC_RAW,   8'd255, 32'hffff_ffff, 15'h7fff);
    send_cmd(CMD_FIND_RAW,    8'd0,   32'hffff_ffff, 15'h0000);
    send_cmd(CMD_RELEASE_RAW, 8'd0,   32'h0,         15'h00ff);
    send_cmd(CMD_RELEASE_RAW, 8'd0,   32'h0,         15'h7fff);
    send_cmd(CMD_RELEASE_RAW, 8'd0,   32'h0,         {7'd2, 8'ha5});
    send_cmd(CMD_FIND_RAW,    8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RESERVED_A,  8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RESERVED_B,  8'd255, 32'hffff_ffff, 15'h7fff);
    send_cmd(CMD_RELEASE_IDX, 8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_RELEASE_IDX, 8'd0,   32'h0,         15'h0000);
    send_cmd(CMD_ALLOC_RAW,   8'd0,   32'h5555_aaaa, 15'h0000);
    send_cmd(CMD_FIND_IDX,    8'd255, 32'h0,         15'h0000);

    for (int seg = 0; seg < 12; seg++) begin
      calm = ($urandom_range(0, 3) == 0);
      repeat (100) random_cmd((seg % 4) < 2);
    end

    // free every raw slot
    calm = 1'b1;
    for (int i = 0; i < 128; i++) begin
      send_cmd(CMD_RELEASE_RAW, 8'd0, 32'h0, {7'(i), 8'($urandom())});
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/rpsa_pkg.sv
sv/rpsa_ctrl.sv
sv/rpsa_datapath.sv
sv/refcounted_palette_slot_allocator.sv
sv/rpsa_checker.sv
verif/palette_alloc_checker.sv
verif/tb.sv
